/* hdl/ddo_pkg.sv */
// Shared types, constants and the arctangent table for the differential-drive
// odometry block. No dependencies.
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int POS_FRAC_BITS_DEF = 8;

    localparam int MUL_W  = 26;               // shared multiplier operand width
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 64;
    localparam int DIV_W  = 41;               // dividend / quotient bits
    localparam int CNT_W  = 6;                // covers DIV_W and up to 24 rotations
    localparam int XY_W   = 42;               // CORDIC x / y width
    localparam int Z_W    = 33;               // CORDIC angle width

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    localparam logic [23:0] SCALE_RESET     = 24'd65536;
    localparam logic [15:0] WHEELBASE_RESET = 16'd1;

    localparam logic [21:0] INV_TWO_PI_Q24 = 22'd2670178;
    localparam logic [19:0] GAIN_INV_Q20   = 20'd636751;
    localparam logic [15:0] MRAD_PER_RAD   = 16'd1000;
    localparam logic [63:0] MRAD_HALF      = 64'd128000;   // half of 1000 * 2^8
    localparam int          MRAD_SHIFT     = 8;
    localparam int          WB_SHIFT       = 23;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCALE_DEFAULT = 3'd0,
        CFG_SCALE_ROTATE  = 3'd1,
        CFG_SCALE_DRIVE   = 3'd2,
        CFG_WHEELBASE     = 3'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_DEFAULT = 2'd0,
        MODE_ROTATE  = 2'd1,
        MODE_DRIVE   = 2'd2
    } motion_mode_t;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_SET    = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_SUM,
        ST_MUL_DIF,
        ST_MUL_TLO,
        ST_MUL_THI,
        ST_MUL_DLO,
        ST_MUL_DHI,
        ST_DIV_PREP,
        ST_DIV,
        ST_ANGLE,
        ST_CORDIC,
        ST_FINISH
    } state_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/diff_drive_odometry_update.sv */
// Differential-drive odometry: pose update by scaled tick differences,
// heading by division through the wheelbase, travel rotated by CORDIC.
// Depends on ddo_pkg.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | cmd, counts, mode, clear, set pose
//  out      | out_valid / out_ready| pos_x, pos_y, heading
//  cfg      | cfg_wr_en            | cfg_index, cfg_wdata (write only)
//
// An update transfer makes six passes through the shared 26x26 multiplier,
// then 41 steps of the restoring divider and CORDIC_STEPS rotations, one per
// cycle. A set-pose transfer makes one multiplier pass and the divider steps.
// Reset clears pose, stored counts and registers to their power-up values.
// A finished pose waits in the output register; a new item is taken meanwhile,
// and its own result holds until the output register is free.
module diff_drive_odometry_update #(
    parameter int CORDIC_STEPS  = ddo_pkg::CORDIC_STEPS_DEF,
    parameter int POS_FRAC_BITS = ddo_pkg::POS_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic signed [15:0]                left_count,
    input  logic signed [15:0]                right_count,
    input  logic [1:0]                        motion_mode,
    input  logic                              clear_after,
    input  logic signed [15:0]                set_x_mm,
    input  logic signed [15:0]                set_y_mm,
    input  logic signed [15:0]                set_heading_mrad,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                pos_x,
    output logic signed [31:0]                pos_y,
    output logic [15:0]                       heading,
    input  logic                              cfg_wr_en,
    input  logic [ddo_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int RND_SHIFT = 16 - POS_FRAC_BITS;
    localparam int MW = ddo_pkg::MUL_W;
    localparam int PW = ddo_pkg::PROD_W;
    localparam int AW = ddo_pkg::ACC_W;
    localparam int DW = ddo_pkg::DIV_W;
    localparam int CW = ddo_pkg::CNT_W;
    localparam int XW = ddo_pkg::XY_W;
    localparam int ZW = ddo_pkg::Z_W;

    // ---------------------------------------------------------------- config
    logic [23:0] scale_default_reg, scale_rotate_reg, scale_drive_reg;
    logic [15:0] wheelbase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_default_reg <= ddo_pkg::SCALE_RESET;
            scale_rotate_reg  <= ddo_pkg::SCALE_RESET;
            scale_drive_reg   <= ddo_pkg::SCALE_RESET;
            wheelbase_reg     <= ddo_pkg::WHEELBASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ddo_pkg::CFG_SCALE_DEFAULT: scale_default_reg <= cfg_wdata;
                ddo_pkg::CFG_SCALE_ROTATE:  scale_rotate_reg  <= cfg_wdata;
                ddo_pkg::CFG_SCALE_DRIVE:   scale_drive_reg   <= cfg_wdata;
                ddo_pkg::CFG_WHEELBASE:     wheelbase_reg     <= cfg_wdata[15:0];
                default: ;   // indexes past the list are dropped
            endcase
        end
    end

    // ----------------------------------------------------------- declarations
    ddo_pkg::state_t state_reg, state_next;

    logic                  in_xfer, out_free, commit;
    logic                  set_reg, clr_reg, dneg_reg, out_valid_reg;
    logic signed [16:0]    sum_reg;          // dL + dR
    logic signed [17:0]    dif_reg;          // dR - dL
    logic [23:0]           scale_reg;
    logic [15:0]           mr_abs_reg;
    logic signed [15:0]    setx_reg, sety_reg;
    logic [15:0]           prev_left_reg, prev_right_reg;
    logic signed [31:0]    pose_x_reg, pose_y_reg;
    logic [15:0]           pose_h_reg;
    logic signed [31:0]    pos_x_reg, pos_y_reg;
    logic [15:0]           heading_reg;

    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  prod_reg;
    logic signed [40:0]    travel_reg;
    logic [39:0]           dmag_reg;
    logic signed [AW-1:0]  acc_reg;
    logic [DW-1:0]         quo_reg;
    logic [15:0]           rem_reg;
    logic [CW-1:0]         cnt_reg;
    logic signed [XW-1:0]  x_reg, y_reg;
    logic signed [ZW-1:0]  z_reg;

    logic signed [15:0]    dl, dr;
    logic [15:0]           den;
    logic [16:0]           trial;
    logic                  trial_ge;
    logic [AW-1:0]         div_mag, div_sum;
    logic signed [DW:0]    a_val;
    logic signed [DW:0]    h_step;
    logic [17:0]           mid18;
    logic signed [31:0]    z32;
    logic signed [XW-1:0]  xs, ys, x_rnd, y_rnd;
    logic signed [ZW-1:0]  atan_z;
    logic signed [31:0]    new_x, new_y;
    logic [15:0]           new_h;
    logic signed [31:0]    sx32, sy32;

    assign in_ready  = (state_reg == ddo_pkg::ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign heading   = heading_reg;

    // wrapping tick differences against the stored counts
    assign dl = signed'(16'(left_count - prev_left_reg));
    assign dr = signed'(16'(right_count - prev_right_reg));

    // divisor: 1000 for a set item, the wheelbase (zero read as one) otherwise
    always_comb
    begin
        if (set_reg)
            den = ddo_pkg::MRAD_PER_RAD;
        else if (wheelbase_reg == 16'd0)
            den = 16'd1;
        else
            den = wheelbase_reg;
    end

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign trial_ge = (trial >= {1'b0, den});

    // ------------------------------------------------------------------ FSM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ddo_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ddo_pkg::ST_IDLE:
            begin
                if (in_xfer)
                    state_next = (cmd == ddo_pkg::CMD_SET) ? ddo_pkg::ST_MUL_DHI
                                                           : ddo_pkg::ST_MUL_SUM;
            end
            ddo_pkg::ST_MUL_SUM:
            begin
                mul_a      = MW'(sum_reg);
                mul_b      = signed'(MW'(scale_reg));
                state_next = ddo_pkg::ST_MUL_DIF;
            end
            ddo_pkg::ST_MUL_DIF:
            begin
                mul_a      = MW'(dif_reg);
                mul_b      = signed'(MW'(scale_reg));
                state_next = ddo_pkg::ST_MUL_TLO;
            end
            ddo_pkg::ST_MUL_TLO:
            begin
                mul_a      = signed'(MW'(travel_reg[23:0]));
                mul_b      = signed'(MW'(ddo_pkg::GAIN_INV_Q20));
                state_next = ddo_pkg::ST_MUL_THI;
            end
            ddo_pkg::ST_MUL_THI:
            begin
                mul_a      = MW'(signed'(travel_reg[40:24]));
                mul_b      = signed'(MW'(ddo_pkg::GAIN_INV_Q20));
                state_next = ddo_pkg::ST_MUL_DLO;
            end
            ddo_pkg::ST_MUL_DLO:
            begin
                mul_a      = signed'(MW'(dmag_reg[23:0]));
                mul_b      = signed'(MW'(ddo_pkg::INV_TWO_PI_Q24));
                state_next = ddo_pkg::ST_MUL_DHI;
            end
            ddo_pkg::ST_MUL_DHI:
            begin
                mul_a      = set_reg ? signed'(MW'(mr_abs_reg))
                                     : signed'(MW'(dmag_reg[39:24]));
                mul_b      = signed'(MW'(ddo_pkg::INV_TWO_PI_Q24));
                state_next = ddo_pkg::ST_DIV_PREP;
            end
            ddo_pkg::ST_DIV_PREP:
                state_next = ddo_pkg::ST_DIV;
            ddo_pkg::ST_DIV:
            begin
                if (cnt_reg == CW'(DW - 1))
                    state_next = set_reg ? ddo_pkg::ST_FINISH : ddo_pkg::ST_ANGLE;
            end
            ddo_pkg::ST_ANGLE:
                state_next = ddo_pkg::ST_CORDIC;
            ddo_pkg::ST_CORDIC:
            begin
                if (cnt_reg == CW'(CORDIC_STEPS - 1))
                    state_next = ddo_pkg::ST_FINISH;
            end
            ddo_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = ddo_pkg::ST_IDLE;
            end
            default:
                state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    assign commit = (state_reg == ddo_pkg::ST_FINISH) && out_free;

    // ------------------------------------------------------- shared multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // --------------------------------------------------------- combinational
    // dividend: (|diff| * K + wb * 2^22) / 2^23, or (|mrad| * K + 128000) / 2^8
    always_comb
    begin
        if (set_reg)
        begin
            div_mag = AW'(prod_reg);
            div_sum = (div_mag + ddo_pkg::MRAD_HALF) >> ddo_pkg::MRAD_SHIFT;
        end
        else
        begin
            div_mag = AW'(acc_reg + (AW'(prod_reg) <<< 24));
            div_sum = (div_mag + (AW'(den) << (ddo_pkg::WB_SHIFT - 1))) >> ddo_pkg::WB_SHIFT;
        end
    end

    // signed heading change in 2^-17 turn (a set item's heading in 2^-16 turn), rounded ties away from zero
    assign a_val  = dneg_reg ? -signed'({1'b0, quo_reg}) : signed'({1'b0, quo_reg});
    assign h_step = (a_val + (DW+1)'(1)) >>> 1;
    assign mid18  = {pose_h_reg, 2'b00} + a_val[17:0];
    assign z32    = signed'({mid18, 14'b0});

    assign xs     = x_reg >>> cnt_reg[4:0];
    assign ys     = y_reg >>> cnt_reg[4:0];
    assign atan_z = signed'(ZW'(ddo_pkg::atan_turn(cnt_reg[4:0])));

    // round to the output fraction, ties toward plus infinity
    assign x_rnd  = (x_reg + (XW'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    assign y_rnd  = (y_reg + (XW'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;

    assign sx32   = 32'(setx_reg) <<< POS_FRAC_BITS;
    assign sy32   = 32'(sety_reg) <<< POS_FRAC_BITS;

    always_comb
    begin
        if (set_reg)
        begin
            new_x = sx32;
            new_y = sy32;
            new_h = a_val[15:0];
        end
        else if (clr_reg)
        begin
            new_x = '0;
            new_y = '0;
            new_h = '0;
        end
        else
        begin
            new_x = pose_x_reg + x_rnd[31:0];
            new_y = pose_y_reg + y_rnd[31:0];
            new_h = pose_h_reg + h_step[15:0];
        end
    end

    // -------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            set_reg    <= cmd;
            clr_reg    <= clear_after;
            sum_reg    <= 17'(dl) + 17'(dr);
            dif_reg    <= 18'(dr) - 18'(dl);
            setx_reg   <= set_x_mm;
            sety_reg   <= set_y_mm;
            dneg_reg   <= set_heading_mrad[15];
            mr_abs_reg <= set_heading_mrad[15] ? 16'(-set_heading_mrad)
                                               : 16'(set_heading_mrad);
            case (motion_mode)
                ddo_pkg::MODE_ROTATE: scale_reg <= scale_rotate_reg;
                ddo_pkg::MODE_DRIVE:  scale_reg <= scale_drive_reg;
                default:              scale_reg <= scale_default_reg;
            endcase
        end

        case (state_reg)
            ddo_pkg::ST_MUL_DIF:
                travel_reg <= 41'(prod_reg >>> 1);
            ddo_pkg::ST_MUL_TLO:
            begin
                dneg_reg <= prod_reg[PW-1];
                dmag_reg <= prod_reg[PW-1] ? 40'(-prod_reg) : 40'(prod_reg);
            end
            ddo_pkg::ST_MUL_THI:
                acc_reg <= AW'(prod_reg);
            ddo_pkg::ST_MUL_DLO:
                x_reg <= XW'((acc_reg + (AW'(prod_reg) <<< 24)) >>> 20);
            ddo_pkg::ST_MUL_DHI:
                acc_reg <= AW'(prod_reg);
            ddo_pkg::ST_DIV_PREP:
            begin
                quo_reg <= div_sum[DW-1:0];
                rem_reg <= '0;
            end
            ddo_pkg::ST_DIV:
            begin
                rem_reg <= trial_ge ? 16'(trial - {1'b0, den}) : trial[15:0];
                quo_reg <= {quo_reg[DW-2:0], trial_ge};
            end
            ddo_pkg::ST_ANGLE:
            begin
                // fold into the right half plane, then rotate from there
                y_reg <= '0;
                if (z32 > 32'sd1073741824)
                begin
                    x_reg <= -x_reg;
                    z_reg <= ZW'(z32) - 33'sd2147483648;
                end
                else if (z32 < -32'sd1073741824)
                begin
                    x_reg <= -x_reg;
                    z_reg <= ZW'(z32) + 33'sd2147483648;
                end
                else
                    z_reg <= ZW'(z32);
            end
            ddo_pkg::ST_CORDIC:
            begin
                if (!z_reg[ZW-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_z;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_z;
                end
            end
            default: ;
        endcase

        if (commit)
        begin
            pos_x_reg   <= new_x;
            pos_y_reg   <= new_y;
            heading_reg <= new_h;
        end
    end

    // ---------------------------------------------------- control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            pose_h_reg     <= '0;
        end
        else
        begin
            // advance the step counter through the divider and the rotations
            if (state_reg == ddo_pkg::ST_DIV_PREP || state_reg == ddo_pkg::ST_ANGLE)
                cnt_reg <= '0;
            else if (state_reg == ddo_pkg::ST_DIV || state_reg == ddo_pkg::ST_CORDIC)
                cnt_reg <= cnt_reg + CW'(1);

            // stored counts follow every update transfer, or clear to zero with clear_after; a set item keeps them
            if (in_xfer && cmd == ddo_pkg::CMD_UPDATE)
            begin
                prev_left_reg  <= clear_after ? 16'd0 : left_count;
                prev_right_reg <= clear_after ? 16'd0 : right_count;
            end

            if (commit)
            begin
                pose_x_reg <= new_x;
                pose_y_reg <= new_y;
                pose_h_reg <= new_h;
            end

            if (commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------ assertions
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input taken while an item is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid)
        else $error("finished pose not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ddo_pkg::ST_DIV) |-> (rem_reg < den))
        else $error("divider remainder out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ddo_pkg::ST_CORDIC) |-> !set_reg)
        else $error("set item entered the rotation");

endmodule

/* tb/sv/diff_drive_odometry_update_tb.sv */
// Self-checking testbench for diff_drive_odometry_update: drives pose updates and
// set-pose items, predicts each pose in-line and compares it with the block output.
// Depends on ddo_pkg and the diff_drive_odometry_update RTL.
module diff_drive_odometry_update_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STEPS         = 16;
    localparam int  FRAC          = 8;
    localparam int  RANDOM_ITEMS  = 900;
    localparam int  DRAIN_CYCLES  = 200;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct packed {
        ddo_pkg::cmd_t     cmd;
        logic [15:0]       left_count;
        logic [15:0]       right_count;
        logic [1:0]        motion_mode;
        logic              clear_after;
        logic [15:0]       set_x_mm;
        logic [15:0]       set_y_mm;
        logic [15:0]       set_heading_mrad;
    } odo_item_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
    } pose_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic cmd;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic [1:0] motion_mode;
    logic clear_after;
    logic signed [15:0] set_x_mm;
    logic signed [15:0] set_y_mm;
    logic signed [15:0] set_heading_mrad;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0] heading;
    logic cfg_wr_en;
    logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ddo_pkg::CFG_DATA_W-1:0] cfg_wdata;

    diff_drive_odometry_update dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .left_count(left_count), .right_count(right_count),
        .motion_mode(motion_mode), .clear_after(clear_after),
        .set_x_mm(set_x_mm), .set_y_mm(set_y_mm), .set_heading_mrad(set_heading_mrad),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Predictor state: registers and pose as the block should hold them.
    logic [23:0] scale_def_q, scale_rot_q, scale_drv_q;
    logic [15:0] wheelbase_q;
    logic [15:0] last_left, last_right;
    logic [31:0] pose_x_q, pose_y_q;
    logic [15:0] pose_hdg_q;

    odo_item_t pending_items[$];
    pose_t     expected_poses[$];

    // Remember whether the item on offer was taken at the last rising edge.
    logic in_ready_seen;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    bit  failed;
    int  poses_checked;
    int  updates_sent;
    int  sets_sent;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor(v / 2^s) for signed values
    function automatic longint floor_sh(input longint v, input int s);
        return v >>> s;
    endfunction

    // num / den rounded to nearest, ties away from zero
    function automatic longint div_near(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint atan_entry(input int i);
        longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81};
        return tbl[i];
    endfunction

    function automatic longint wrap_delta(input logic [15:0] now, input logic [15:0] was);
        logic signed [15:0] d;
        d = now - was;
        return longint'(d);
    endfunction

    // Advance the predicted pose by one item and return what the block should report.
    function automatic pose_t predict_pose(input odo_item_t it);
        pose_t  p;
        logic [23:0] scale;
        longint wb, sl, sr, travel, ang_chg, z, cx, cy, xs, ys, hv;
        logic [17:0] mid18;
        logic [31:0] ang32;
        if (it.cmd == ddo_pkg::CMD_SET)
        begin
            hv = div_near(longint'($signed(it.set_heading_mrad)) * 2670178, 256000);
            pose_x_q = 32'(longint'($signed(it.set_x_mm)) <<< FRAC);
            pose_y_q = 32'(longint'($signed(it.set_y_mm)) <<< FRAC);
            pose_hdg_q = 16'(hv);
        end
        else
        begin
            case (it.motion_mode)
                ddo_pkg::MODE_ROTATE: scale = scale_rot_q;
                ddo_pkg::MODE_DRIVE:  scale = scale_drv_q;
                default:              scale = scale_def_q;
            endcase
            wb = (wheelbase_q == 0) ? 1 : longint'(wheelbase_q);
            sl = wrap_delta(it.left_count, last_left) * longint'(scale);
            sr = wrap_delta(it.right_count, last_right) * longint'(scale);
            travel = floor_sh(sl + sr, 1);
            ang_chg = div_near((sr - sl) * 2670178, wb <<< 23);
            mid18 = 18'(longint'(pose_hdg_q) * 4 + ang_chg);
            ang32 = {mid18, 14'd0};
            z = longint'($signed(ang32));
            cx = floor_sh(travel * 636751, 20);
            cy = 0;
            // Fold the angle into the right half plane.
            if (z > (64'sd1 <<< 30))
            begin
                cx = -cx;
                z -= 64'sd1 <<< 31;
            end
            else if (z < -(64'sd1 <<< 30))
            begin
                cx = -cx;
                z += 64'sd1 <<< 31;
            end
            for (int i = 0; i < STEPS; i++)
            begin
                xs = floor_sh(cx, i);
                ys = floor_sh(cy, i);
                if (z >= 0)
                begin
                    cx -= ys;
                    cy += xs;
                    z -= atan_entry(i);
                end
                else
                begin
                    cx += ys;
                    cy -= xs;
                    z += atan_entry(i);
                end
            end
            pose_x_q = pose_x_q + 32'(floor_sh(cx + (64'sd1 <<< (15 - FRAC)), 16 - FRAC));
            pose_y_q = pose_y_q + 32'(floor_sh(cy + (64'sd1 <<< (15 - FRAC)), 16 - FRAC));
            pose_hdg_q = pose_hdg_q + 16'(floor_sh(ang_chg + 1, 1));
            last_left = it.left_count;
            last_right = it.right_count;
            if (it.clear_after)
            begin
                pose_x_q = '0;
                pose_y_q = '0;
                pose_hdg_q = '0;
                last_left = '0;
                last_right = '0;
            end
        end
        p.pos_x = pose_x_q;
        p.pos_y = pose_y_q;
        p.heading = pose_hdg_q;
        return p;
    endfunction

    // Driver: present the head of the queue, change inputs on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready_seen)
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                odo_item_t it;
                it = pending_items.pop_front();
                expected_poses.push_back(predict_pose(it));
                if (it.cmd == ddo_pkg::CMD_SET)
                    sets_sent++;
                else
                    updates_sent++;
                cmd <= it.cmd;
                left_count <= it.left_count;
                right_count <= it.right_count;
                motion_mode <= it.motion_mode;
                clear_after <= it.clear_after;
                set_x_mm <= it.set_x_mm;
                set_y_mm <= it.set_y_mm;
                set_heading_mrad <= it.set_heading_mrad;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        in_ready_seen <= in_valid && in_ready;

    // Receiver readiness: random stalls, or a long hold-off counted here.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each pose transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_poses.size() == 0)
            begin
                $error("pose transfer with nothing expected: x=%h y=%h h=%h",
                       pos_x, pos_y, heading);
                failed = 1'b1;
            end
            else
            begin
                pose_t e;
                e = expected_poses.pop_front();
                poses_checked++;
                if (pos_x !== e.pos_x)
                begin
                    $error("pos_x expected %h actual %h", e.pos_x, pos_x);
                    failed = 1'b1;
                end
                if (pos_y !== e.pos_y)
                begin
                    $error("pos_y expected %h actual %h", e.pos_y, pos_y);
                    failed = 1'b1;
                end
                if (heading !== e.heading)
                begin
                    $error("heading expected %h actual %h", e.heading, heading);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("diff_drive_odometry_update verification failed");
            $finish;
        end
    end

    function automatic odo_item_t make_update(input logic [15:0] l, input logic [15:0] r,
                                              input logic [1:0] mode, input logic clr);
        odo_item_t it;
        it = '0;
        it.cmd = ddo_pkg::CMD_UPDATE;
        it.left_count = l;
        it.right_count = r;
        it.motion_mode = mode;
        it.clear_after = clr;
        it.set_x_mm = 16'($urandom);
        it.set_y_mm = 16'($urandom);
        it.set_heading_mrad = 16'($urandom);
        return it;
    endfunction

    function automatic odo_item_t make_set(input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] mrad);
        odo_item_t it;
        it = make_update(16'($urandom), 16'($urandom), 2'($urandom), 1'($urandom));
        it.cmd = ddo_pkg::CMD_SET;
        it.set_x_mm = x;
        it.set_y_mm = y;
        it.set_heading_mrad = mrad;
        return it;
    endfunction

    // Write one register while idle; mirror it in the predictor.
    task automatic write_reg(input ddo_pkg::cfg_index_t idx, input logic [23:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            ddo_pkg::CFG_SCALE_DEFAULT: scale_def_q = val;
            ddo_pkg::CFG_SCALE_ROTATE:  scale_rot_q = val;
            ddo_pkg::CFG_SCALE_DRIVE:   scale_drv_q = val;
            ddo_pkg::CFG_WHEELBASE:     wheelbase_q = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Let the queue empty and every pose arrive, then allow the block to settle.
    task automatic drain;
        while (pending_items.size() != 0 || in_valid || expected_poses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [23:0] sd, input logic [23:0] sr,
                            input logic [23:0] sv, input logic [15:0] wb);
        write_reg(ddo_pkg::CFG_SCALE_DEFAULT, sd);
        write_reg(ddo_pkg::CFG_SCALE_ROTATE, sr);
        write_reg(ddo_pkg::CFG_SCALE_DRIVE, sv);
        write_reg(ddo_pkg::CFG_WHEELBASE, {8'd0, wb});
    endtask

    // Random items: mostly small wheel motion from the last counts, some wild jumps and set-pose items.
    task automatic queue_random(input int n);
        logic [15:0] l, r;
        l = last_left;
        r = last_right;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0:
                    pending_items.push_back(make_set(16'($urandom), 16'($urandom),
                                                     16'($urandom)));
                1:
                begin
                    l = 16'($urandom);
                    r = 16'($urandom);
                    pending_items.push_back(make_update(l, r, 2'($urandom),
                                            ($urandom_range(7) == 0)));
                end
                default:
                begin
                    l = l + 16'($urandom_range(400)) - 16'd200;
                    r = r + 16'($urandom_range(400)) - 16'd200;
                    pending_items.push_back(make_update(l, r, 2'($urandom),
                                            ($urandom_range(19) == 0)));
                end
            endcase
        end
    endtask

    initial
    begin
        int per_phase;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cmd = ddo_pkg::CMD_UPDATE;
        left_count = '0;
        right_count = '0;
        motion_mode = ddo_pkg::MODE_DEFAULT;
        clear_after = 1'b0;
        set_x_mm = '0;
        set_y_mm = '0;
        set_heading_mrad = '0;
        cfg_wr_en = 1'b0;
        cfg_index = ddo_pkg::CFG_SCALE_DEFAULT;
        cfg_wdata = '0;
        in_ready_seen = 1'b0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        failed = 1'b0;
        poses_checked = 0;
        updates_sent = 0;
        sets_sent = 0;
        cycle_count = 0;
        scale_def_q = ddo_pkg::SCALE_RESET;
        scale_rot_q = ddo_pkg::SCALE_RESET;
        scale_drv_q = ddo_pkg::SCALE_RESET;
        wheelbase_q = ddo_pkg::WHEELBASE_RESET;
        last_left = '0;
        last_right = '0;
        pose_x_q = '0;
        pose_y_q = '0;
        pose_hdg_q = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset register values, then with a zero wheelbase, then with a real wheelbase.
        pending_items.push_back(make_update(16'd100, 16'd100, ddo_pkg::MODE_DEFAULT, 1'b0));
        pending_items.push_back(make_update(16'h7FFF, 16'h8000, ddo_pkg::MODE_ROTATE, 1'b0));
        pending_items.push_back(make_update(16'h8000, 16'h7FFF, ddo_pkg::MODE_DRIVE, 1'b0));
        pending_items.push_back(make_update(16'hFFFF, 16'h0000, 2'd3, 1'b0));
        pending_items.push_back(make_update(16'h1234, 16'h4321, ddo_pkg::MODE_DEFAULT, 1'b1));
        pending_items.push_back(make_set(16'h7FFF, 16'h8000, 16'h7FFF));
        pending_items.push_back(make_set(16'h8000, 16'h7FFF, 16'h8000));
        pending_items.push_back(make_set(16'h0000, 16'hFFFF, 16'd3142));
        pending_items.push_back(make_update(16'd50, 16'hFFCE, ddo_pkg::MODE_DRIVE, 1'b0));
        drain();
        set_regs(24'hFFFFFF, 24'h000000, 24'h00C000, 16'd0);   // zero wheelbase acts as one
        write_reg(ddo_pkg::cfg_index_t'(3'd5), 24'h123456);    // out-of-range index is dropped
        pending_items.push_back(make_update(16'h7FFF, 16'h8001, ddo_pkg::MODE_DEFAULT, 1'b0));
        pending_items.push_back(make_update(16'h0000, 16'h0000, ddo_pkg::MODE_ROTATE, 1'b0));
        pending_items.push_back(make_update(16'h8000, 16'h7FFF, ddo_pkg::MODE_DRIVE, 1'b0));
        pending_items.push_back(make_set(16'd10, 16'hFFF6, 16'hF000));
        pending_items.push_back(make_update(16'h0100, 16'h0300, 2'd3, 1'b1));
        drain();
        set_regs(24'h010000, 24'h00A000, 24'h018000, 16'hFFFF);
        pending_items.push_back(make_update(16'h8000, 16'h7FFF, ddo_pkg::MODE_DEFAULT, 1'b0));
        pending_items.push_back(make_update(16'h8001, 16'h8000, ddo_pkg::MODE_ROTATE, 1'b0));
        drain();

        // Random phases with varied idling and register settings.
        per_phase = RANDOM_ITEMS / 5;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:       set_regs(24'h00F000, 24'h00E000, 24'h011000, 16'd300);
                1:       set_regs(24'($urandom), 24'($urandom), 24'($urandom),
                                  16'($urandom_range(65535, 1)));
                2:       set_regs(24'h000001, 24'hFFFFFF, 24'h010000, 16'd1);
                3:       set_regs(24'h006000, 24'h008000, 24'h00A000, 16'd150);
                default: set_regs(24'($urandom_range(200000)), 24'($urandom_range(200000)),
                                  24'($urandom_range(200000)), 16'($urandom_range(2000, 50)));
            endcase
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 47 : 20) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 47 : 20) : 0;
            queue_random(per_phase);
            // Hold the receiver off long enough for the block to back up its input.
            if (ph == 4)
            begin
                @(negedge clk);
                hold_off_cycles = 600;
            end
            drain();
        end

        $display("Covered %0d updates and %0d set-pose items, %0d poses checked,",
                 updates_sent, sets_sent, poses_checked);
        $display("across register extremes, zero wheelbase, clears and backpressure.");
        if (!failed)
            $display("diff_drive_odometry_update verification clean");
        else
            $display("diff_drive_odometry_update verification failed");
        $finish;
    end

endmodule
